// ===== hdl/pfd_pkg.sv =====
// Shared types and constants for the PLL fractional divider parameter block.
`default_nettype none
package pfd_pkg;

  localparam int FREQ_W = 32;
  localparam int ODIV_W = 8;
  localparam int REF_W  = 32;
  localparam int A_W    = 8;
  localparam int P1_W   = 24;
  localparam int P2_W   = 14;
  localparam int P3_W   = 20;
  localparam int FRAC_EXTRA = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam logic [REF_W-1:0] REF_RESET = 32'd25000080;
  localparam logic [P1_W-1:0]  P1_OFFSET = 24'd512;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/pll_fractional_divider_params_top.sv =====
// Top level: PLL feedback divider parameters P1, P2, P3 from frequency and output divider.
// One beat in gives one beat out. The beat's frequency and divider are multiplied on
// acceptance, then a single restoring divider by reference_hz runs one quotient bit per
// cycle over an ARITH_BITS + DENOM_LOG2 + 7 bit quotient (61 bits by default), covering
// both the integer ratio and the scaled fraction; a final state waits until the output
// register is free, then forms P1 and loads it. The next beat is taken only after
// that load, and may be taken while the previous result still waits in the output
// register. A reference of zero yields all-ones quotients.
`default_nettype none
module pll_fractional_divider_params_top
  import pfd_pkg::*;
#(
  parameter int ARITH_BITS = 40,
  parameter int DENOM_LOG2 = 14
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire [REF_W-1:0]        cfg_wr_data,    // reference_hz
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,       // out_freq_hz[31:0], out_divider[39:32]
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata       // int_ratio[7:0], p1_word[31:8],
                                                 // p2_word[45:32], p3_word[65:46], zero
);

  localparam int BBITS  = DENOM_LOG2 + FRAC_EXTRA;
  localparam int NSTEPS = ARITH_BITS + BBITS;
  localparam int CNT_W  = $clog2(NSTEPS);
  localparam int PROD_W = FREQ_W + ODIV_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEPS - 1);
  localparam logic [BBITS-1:0] DMASK    = BBITS'((64'd1 << DENOM_LOG2) - 64'd1);
  localparam logic [P3_W-1:0]  P3_VAL   = P3_W'(64'd1 << DENOM_LOG2);

  state_t              state_r, state_nxt;
  logic [REF_W-1:0]    ref_r;
  logic [NSTEPS-1:0]   sreg_r, sreg_nxt;
  logic [REF_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [PROD_W-1:0]   prod;
  logic [REF_W:0]      trial;
  logic [REF_W:0]      diff;
  logic                qbit;
  logic [A_W-1:0]      a_val;
  logic [BBITS-1:0]    b_val;
  logic [P1_W-1:0]     p1_val;
  logic [P2_W-1:0]     p2_val;
  logic                out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign prod  = PROD_W'(in_tdata[FREQ_W-1:0]) * PROD_W'(in_tdata[FREQ_W +: ODIV_W]);
  assign trial = {rem_r, sreg_r[NSTEPS-1]};
  assign diff  = trial - {1'b0, ref_r};
  assign qbit  = (trial >= {1'b0, ref_r});

  assign a_val  = sreg_r[BBITS +: A_W];
  assign b_val  = sreg_r[BBITS-1:0];
  assign p1_val = P1_W'({a_val, 7'b0}) + P1_W'(b_val[BBITS-1 -: FRAC_EXTRA]) - P1_OFFSET;
  assign p2_val = P2_W'(b_val & DMASK);

  always_comb begin
    state_nxt     = state_r;
    sreg_nxt      = sreg_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sreg_nxt  = {ARITH_BITS'(prod), {BBITS{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = qbit ? diff[REF_W-1:0] : trial[REF_W-1:0];
        sreg_nxt = {sreg_r[NSTEPS-2:0], qbit};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_nxt  = {{(OUT_TDATA_W - A_W - P1_W - P2_W - P3_W){1'b0}},
                           P3_VAL, p2_val, p1_val, a_val};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_r       <= REF_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        ref_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sreg_r     <= sreg_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
